[src/filtered_limit_positioner_unit_defines.svh]
// ----------------------------------------------------------------------------
// Filtered limit positioner assertion macros
// Shared concurrent assertion forms for the positioner RTL.
// ----------------------------------------------------------------------------
`ifndef FILTERED_LIMIT_POSITIONER_UNIT_DEFINES_SVH
`define FILTERED_LIMIT_POSITIONER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FLP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define FLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/flp_pkg.sv]
// ----------------------------------------------------------------------------
// Filtered limit positioner package
// Widths, register codes, reset values and word types of the positioner.
// ----------------------------------------------------------------------------
package flp_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int CMD_W       = 2;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   // 19*level + sample < 20 * 2**SAMPLE_BITS < 2**(SAMPLE_BITS+5)
   localparam int SUM_W       = SAMPLE_BITS + 5;
   localparam int QUOT_W      = SUM_W - 2;
   localparam int RECIP_W     = SAMPLE_BITS + 1;
   localparam int PROD_W      = QUOT_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_FIVE = RECIP_W'((1 << QUOT_W) / 5);

   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RAISE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOWER  = 2'd2;

   localparam logic REG_LOWER_LIMIT = 1'b0;
   localparam logic REG_UPPER_LIMIT = 1'b1;

   localparam logic [SAMPLE_BITS-1:0] LOWER_LIMIT_RESET = SAMPLE_BITS'(2960);
   localparam logic [SAMPLE_BITS-1:0] UPPER_LIMIT_RESET = SAMPLE_BITS'(3500);

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_DOWN = 2'd1,
      MODE_UP   = 2'd2
   } flp_mode_type;

   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic [SAMPLE_BITS-1:0] sample;
   } flp_req_type;

   typedef struct packed {
      logic                   motor_enable;
      logic                   motor_direction;
      logic                   done_res;
      logic [SAMPLE_BITS-1:0] filtered_level;
      logic [1:0]             move_mode;
   } flp_rsp_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] lower_limit;
      logic [SAMPLE_BITS-1:0] upper_limit;
   } flp_limits_type;

endpackage

[src/flp_csr.sv]
// ----------------------------------------------------------------------------
// Filtered limit positioner register file
// APB-style access to the lower and upper position limits.
// ----------------------------------------------------------------------------
module flp_csr
   import flp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic                pready,
   output logic [DATA_W-1:0]   prdata,
   output flp_limits_type      limits
);

   flp_limits_type limits_ff;
   flp_limits_type limits_in;
   logic           reg_sel;
   logic           write_en;

   assign reg_sel  = paddr[ADDR_W-1];
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign limits   = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_LOWER_LIMIT: limits_in.lower_limit = pwdata[SAMPLE_BITS-1:0];
            REG_UPPER_LIMIT: limits_in.upper_limit = pwdata[SAMPLE_BITS-1:0];
            default:         limits_in = limits_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_LOWER_LIMIT: prdata = DATA_W'(limits_ff.lower_limit);
         REG_UPPER_LIMIT: prdata = DATA_W'(limits_ff.upper_limit);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.lower_limit <= LOWER_LIMIT_RESET;
         limits_ff.upper_limit <= UPPER_LIMIT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

[src/flp_filter.sv]
// ----------------------------------------------------------------------------
// Filtered limit positioner average filter
// Next level = floor((19 * level + sample) / 20), by reciprocal and one fix-up.
// ----------------------------------------------------------------------------
module flp_filter
   import flp_pkg::*;
(
   input  logic [SAMPLE_BITS-1:0] level,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic [SAMPLE_BITS-1:0] next_level
);

   logic [SUM_W-1:0]   sum;
   logic [QUOT_W-1:0]  quarter;
   logic [PROD_W-1:0]  prod;
   logic [RECIP_W-1:0] quot_est;
   logic [QUOT_W-1:0]  rem;
   logic               fix_up;

   assign sum      = (SUM_W'(level) << 4) + (SUM_W'(level) << 1) + SUM_W'(level)
                   + SUM_W'(sample);
   // divide by 4, then by 5
   assign quarter  = sum[SUM_W-1:2];
   assign prod     = PROD_W'(quarter) * PROD_W'(RECIP_FIVE);
   assign quot_est = prod[PROD_W-1:QUOT_W];
   assign rem      = quarter - ((QUOT_W'(quot_est) << 2) + QUOT_W'(quot_est));
   assign fix_up   = (rem >= QUOT_W'(5));

   assign next_level = SAMPLE_BITS'(quot_est + RECIP_W'(fix_up));

endmodule

[src/flp_pipe.sv]
// ----------------------------------------------------------------------------
// Filtered limit positioner pipeline
// Input register, filter and move control, result register with held state.
// ----------------------------------------------------------------------------
`include "filtered_limit_positioner_unit_defines.svh"

module flp_pipe
   import flp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  flp_limits_type limits,
   input  logic           req_valid,
   output logic           req_stall,
   input  flp_req_type    req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output flp_rsp_type    rsp_data
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   flp_req_type            in_ff;
   flp_req_type            in_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   flp_rsp_type            rsp_ff;
   flp_rsp_type            rsp_in;
   logic [SAMPLE_BITS-1:0] level_ff;
   logic [SAMPLE_BITS-1:0] level_in;
   flp_mode_type           mode_ff;
   flp_mode_type           mode_in;
   logic                   enable_ff;
   logic                   enable_in;
   logic                   direction_ff;
   logic                   direction_in;
   logic                   done;
   logic                   advance;
   logic [SAMPLE_BITS-1:0] filtered;

   flp_filter u_filter (
      .level      (level_ff),
      .sample     (in_ff.sample),
      .next_level (filtered)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_in       = req_data;
      end
   end

   always_comb begin
      level_in     = level_ff;
      mode_in      = mode_ff;
      enable_in    = enable_ff;
      direction_in = direction_ff;
      done         = 1'b0;
      unique case (in_ff.command)
         CMD_SAMPLE: begin
            level_in = filtered;
            unique case (mode_ff)
               MODE_DOWN: begin
                  if (filtered > limits.lower_limit) begin
                     direction_in = 1'b0;
                     enable_in    = 1'b1;
                  end else begin
                     enable_in = 1'b0;
                     mode_in   = MODE_IDLE;
                     done      = 1'b1;
                  end
               end
               MODE_UP: begin
                  if (filtered < limits.upper_limit) begin
                     direction_in = 1'b1;
                     enable_in    = 1'b1;
                  end else begin
                     enable_in = 1'b0;
                     mode_in   = MODE_IDLE;
                     done      = 1'b1;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
         CMD_RAISE: begin
            if (mode_ff == MODE_IDLE) begin
               mode_in = MODE_DOWN;
            end
         end
         CMD_LOWER: begin
            if (mode_ff == MODE_IDLE) begin
               mode_in = MODE_UP;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in           = 1'b1;
         rsp_in.motor_enable    = enable_in;
         rsp_in.motor_direction = direction_in;
         rsp_in.done_res        = done;
         rsp_in.filtered_level  = level_in;
         rsp_in.move_mode       = mode_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         mode_ff      <= MODE_IDLE;
         enable_ff    <= 1'b0;
         direction_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            level_ff     <= level_in;
            mode_ff      <= mode_in;
            enable_ff    <= enable_in;
            direction_ff <= direction_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   `FLP_ASSERT_SAME(a_done_stops, clock, reset,
      rsp_valid_ff && rsp_ff.done_res,
      !rsp_ff.motor_enable && (rsp_ff.move_mode == MODE_IDLE),
      "done word with motor still driven or mode not idle")
   `FLP_ASSERT_SAME(a_enable_moving, clock, reset,
      rsp_valid_ff && rsp_ff.motor_enable,
      (rsp_ff.move_mode == MODE_DOWN) || (rsp_ff.move_mode == MODE_UP),
      "motor driven while idle")
   `FLP_ASSERT_NEXT(a_raise_starts, clock, reset,
      advance && (in_ff.command == CMD_RAISE) && (mode_ff == MODE_IDLE),
      mode_ff == MODE_DOWN,
      "raise request from idle did not start a downward move")
   `FLP_ASSERT_NEXT(a_level_hold, clock, reset,
      advance && (in_ff.command != CMD_SAMPLE),
      $stable(level_ff),
      "filtered level changed on a request word")

endmodule

[src/filtered_limit_positioner_unit.sv]
// ----------------------------------------------------------------------------
// Filtered limit positioner unit
// Averaged potentiometer feedback drives a DC motor to a configured limit.
// ----------------------------------------------------------------------------
// Input words (req_) carry a command and a converter sample: a sample tick
// updates the average level and advances an active move, a raise request
// starts a move down to lower_limit, a lower request a move up to
// upper_limit. Requests are taken only when idle. Every input word gives one
// result word (rsp_) with the held motor outputs, a done pulse, the average
// level and the move mode.
// A word accepted into the input register is registered again in the result
// register, from which the receiver takes it. Throughput is one word per
// cycle while rsp_stall is low; the average update and limit compare are
// combinational against the state registers.
// Reset clears the average to zero, the mode to idle, the motor outputs to
// off and down, and loads the limits with 2960 and 3500. When the receiver
// stalls, the result register holds, and req_stall rises as soon as the
// input register also holds a word.
// Limits sit at byte addresses 0 and 4 of the APB-style port; write them only
// while no word is in flight.
// ----------------------------------------------------------------------------
module filtered_limit_positioner_unit
   import flp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  flp_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output flp_rsp_type       rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic              pready,
   output logic [DATA_W-1:0] prdata
);

   flp_limits_type limits;

   flp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .pready  (pready),
      .prdata  (prdata),
      .limits  (limits)
   );

   flp_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .limits    (limits),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
